// ===== rtl/ptb_pkg.sv =====
// Shared types, constants and operation codes of the profiling timer bank.
`default_nettype none
package ptb_pkg;

  // Bank geometry.
  localparam int TIMER_COUNT    = 34;
  localparam int AVERAGE_WINDOW = 8;
  localparam int IDX_W          = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

  // Field widths.
  localparam int OP_W     = 4;
  localparam int TIDX_W   = 6;
  localparam int STAMP_W  = 64;
  localparam int DELTA_W  = 32;
  localparam int COUNT_W  = 4;
  localparam int MILL_W   = 13;
  localparam int THOU_W   = 10;
  localparam int UNITS_W  = 10;

  // Arithmetic constants.
  localparam logic [DELTA_W-1:0] START_ADJUST = 32'd100;
  localparam logic [19:0]        ONE_MILLION  = 20'd1000000;
  localparam logic [9:0]         ONE_THOUSAND = 10'd1000;
  // Reciprocals: ceil(2^32 / 1e6) and ceil(2^20 / 1e3); the estimate is exact or one high.
  localparam logic [12:0]        RECIP_MILLION  = 13'd4295;
  localparam logic [10:0]        RECIP_THOUSAND = 11'd1049;

  // Divider: quotient bits retired per cycle and the cycle count.
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = DELTA_W / DIV_BITS;

  // Padded beat widths.
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 104;

  typedef enum logic [OP_W-1:0] {
    OP_START     = 4'd0,
    OP_START_ADJ = 4'd1,
    OP_STOP      = 4'd2,
    OP_SET_DELTA = 4'd3,
    OP_ACCUM     = 4'd4,
    OP_READ      = 4'd5,
    OP_CLR_ONE   = 4'd6,
    OP_CLR_ALL   = 4'd7,
    OP_CLR_AVG   = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_MUL4
  } state_t;

  // One timer as stored in the bank memory.
  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [DELTA_W-1:0] delta;
    logic [DELTA_W-1:0] sum;
    logic [COUNT_W-1:0] count;
  } timer_entry_t;

  localparam int ENTRY_W = $bits(timer_entry_t);

endpackage
`default_nettype wire

// ===== rtl/profiling_timer_bank_with_average.sv =====
// Top level of the profiling timer bank: sequencer, average divider and decimal split.
//
//   Channel | Dir | Handshake            | Payload
//   --------+-----+----------------------+------------------------------------------------
//   in_     | in  | in_tvalid/in_tready  | in_tdata: operation, timer_index, timestamp,
//           |     |                      |           new_delta
//   out_    | out | out_tvalid/out_tready| out_tdata: sample_count, last_delta,
//           |     |                      |            average_cycles, millions, thousands, units
//
// One beat is worked on at a time. After acceptance the entry is read from the bank memory,
// modified and written back, then its sum is divided by its count (eight quotient bits per
// step, skipped when the count is zero or the index is out of range) and split into decimal
// groups. A new beat is accepted only after the split of the last one is done.
// The result sits in an output register, so a stalled output holds only the final step.
// Reset clears the valid bits of the bank, so every timer reads as zero afterwards.
`default_nettype none
module profiling_timer_bank_with_average
  import ptb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [3:0] operation, [9:4] timer_index, [73:10] timestamp, [105:74] new_delta, rest zero
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [3:0] sample_count, [35:4] last_delta, [67:36] average_cycles, [80:68] millions_part,
  // [90:81] thousands_part, [100:91] units_part, rest zero
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  // Input fields.
  logic [OP_W-1:0]    in_op;
  logic [TIDX_W-1:0]  in_tidx;
  logic [STAMP_W-1:0] in_stamp;
  logic [DELTA_W-1:0] in_ndelta;
  logic               in_tok;
  logic [IDX_W-1:0]   in_addr;
  logic               accept;

  assign in_op     = in_tdata[3:0];
  assign in_tidx   = in_tdata[9:4];
  assign in_stamp  = in_tdata[73:10];
  assign in_ndelta = in_tdata[105:74];
  assign in_tok    = ({1'b0, in_tidx} < (TIDX_W + 1)'(TIMER_COUNT));
  assign in_addr   = in_tok ? in_tidx[IDX_W-1:0] : '0;

  // Control and datapath registers.
  state_t               state_r, state_nxt;
  logic [TIMER_COUNT-1:0] vstamp_r, vstamp_nxt;
  logic [TIMER_COUNT-1:0] vavg_r, vavg_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;

  logic [OP_W-1:0]      op_r;
  logic                 tok_r;
  logic [IDX_W-1:0]     addr_r;
  logic [STAMP_W-1:0]   stamp_in_r;
  logic [DELTA_W-1:0]   ndelta_r;

  logic [COUNT_W-1:0]   cnt_r;
  logic [DELTA_W-1:0]   delta_r;
  logic [DELTA_W-1:0]   avg_r, avg_nxt;
  logic [DELTA_W-1:0]   dq_r, dq_nxt;
  logic [COUNT_W-1:0]   rem_r, rem_nxt;
  logic [$clog2(DIV_STEPS+1)-1:0] step_r;

  logic [MILL_W-1:0]    mq_r;
  logic [MILL_W-1:0]    mill_r;
  logic [19:0]          mrem_r;
  logic [10:0]          tq_r;

  logic [OUT_DATA_W-1:0] out_data_r;

  // Memory port.
  logic               ram_we;
  logic [IDX_W-1:0]   ram_addr;
  timer_entry_t       ram_rdata;
  timer_entry_t       ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;

  ptb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TIMER_COUNT)
  ) u_bank (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = timer_entry_t'(ram_rdata_raw);

  // Entry as seen after the valid bits and the whole-bank clears are applied.
  timer_entry_t ent_eff;
  timer_entry_t ent_new;
  logic         ent_write;
  logic [COUNT_W:0] acc_cnt;

  always_comb begin
    ent_eff = ram_rdata;
    if (!(vstamp_r[addr_r] && (op_r != OP_CLR_ALL))) begin
      ent_eff.stamp = '0;
      ent_eff.delta = '0;
    end
    if (!(vavg_r[addr_r] && (op_r != OP_CLR_AVG))) begin
      ent_eff.sum   = '0;
      ent_eff.count = '0;
    end
  end

  // Per-timer operation applied to the effective entry.
  always_comb begin
    ent_new   = ent_eff;
    ent_write = 1'b0;
    acc_cnt   = {1'b0, ent_eff.count} + 1'b1;
    unique case (op_r)
      OP_START: begin
        ent_new.stamp = stamp_in_r;
        ent_write     = 1'b1;
      end
      OP_START_ADJ: begin
        ent_new.stamp = {stamp_in_r[STAMP_W-1:DELTA_W], stamp_in_r[DELTA_W-1:0] - START_ADJUST};
        ent_write     = 1'b1;
      end
      OP_STOP: begin
        ent_new.delta = stamp_in_r[DELTA_W-1:0] - ent_eff.stamp[DELTA_W-1:0];
        ent_write     = 1'b1;
      end
      OP_SET_DELTA: begin
        ent_new.delta = ndelta_r;
        ent_write     = 1'b1;
      end
      OP_ACCUM: begin
        if ((ent_eff.delta != '0) || (ent_eff.count != '0)) begin
          if (acc_cnt > (COUNT_W + 1)'(AVERAGE_WINDOW)) begin
            ent_new.count = COUNT_W'(1);
            ent_new.sum   = ent_eff.delta + 1'b1;
          end else begin
            ent_new.count = acc_cnt[COUNT_W-1:0];
            ent_new.sum   = ent_eff.sum + ent_eff.delta;
          end
          ent_write = 1'b1;
        end
      end
      OP_CLR_ONE: begin
        ent_new.stamp = '0;
        ent_new.delta = '0;
        ent_write     = 1'b1;
      end
      default: begin
        ent_new = ent_eff;
      end
    endcase
    ram_wdata = ent_new;
  end

  // Restoring divider, eight quotient bits per cycle on a four-bit divisor.
  logic [COUNT_W:0] trial;
  always_comb begin
    dq_nxt  = dq_r;
    rem_nxt = rem_r;
    trial   = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial  = {rem_nxt, dq_nxt[DELTA_W-1]};
      dq_nxt = {dq_nxt[DELTA_W-2:0], 1'b0};
      if (trial >= {1'b0, cnt_r}) begin
        trial     = trial - {1'b0, cnt_r};
        dq_nxt[0] = 1'b1;
      end
      rem_nxt = trial[COUNT_W-1:0];
    end
  end

  // Decimal split arithmetic.
  logic [44:0] mq_prod;
  logic [32:0] mq_back;
  logic [33:0] mdiff;
  logic [30:0] tq_prod;
  logic [20:0] tq_back;
  logic [21:0] tdiff;
  logic [THOU_W-1:0]  thou_val;
  logic [UNITS_W-1:0] units_val;

  always_comb begin
    mq_prod = 45'(avg_r) * 45'(RECIP_MILLION);
    mq_back = 33'(mq_r) * 33'(ONE_MILLION);
    mdiff   = {2'b00, avg_r} - {1'b0, mq_back};
    tq_prod = 31'(mrem_r) * 31'(RECIP_THOUSAND);
    tq_back = 21'(tq_r) * 21'(ONE_THOUSAND);
    tdiff   = {2'b00, mrem_r} - {1'b0, tq_back};
    if (tdiff[21]) begin
      thou_val  = THOU_W'(tq_r - 1'b1);
      units_val = UNITS_W'(tdiff + 22'(ONE_THOUSAND));
    end else begin
      thou_val  = THOU_W'(tq_r);
      units_val = UNITS_W'(tdiff);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (tok_r && (ent_new.count != '0)) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_MUL1;
        end
      end
      ST_DIV: begin
        if (step_r == ($bits(step_r))'(DIV_STEPS - 1)) begin
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_MUL3;
      ST_MUL3: state_nxt = ST_MUL4;
      ST_MUL4: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_tready      = 1'b0;
    accept         = 1'b0;
    ram_we         = 1'b0;
    ram_addr       = addr_r;
    vstamp_nxt     = vstamp_r;
    vavg_nxt       = vavg_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    avg_nxt        = avg_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        accept    = in_tvalid;
        ram_addr  = in_addr;
      end
      ST_READ: begin
        if (op_r == OP_CLR_ALL) begin
          vstamp_nxt = '0;
        end
        if (op_r == OP_CLR_AVG) begin
          vavg_nxt = '0;
        end
        if (tok_r && ent_write) begin
          ram_we             = 1'b1;
          vstamp_nxt[addr_r] = 1'b1;
          vavg_nxt[addr_r]   = 1'b1;
        end
        avg_nxt = tok_r ? ent_new.delta : '0;
      end
      ST_DIV: begin
        if (step_r == ($bits(step_r))'(DIV_STEPS - 1)) begin
          avg_nxt = dq_nxt + 1'b1;
        end
      end
      ST_MUL4: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
        end
      end
      default: begin
        ram_addr = addr_r;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      vstamp_r     <= '0;
      vavg_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      vstamp_r     <= vstamp_nxt;
      vavg_r       <= vavg_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    avg_r <= avg_nxt;
    if (accept) begin
      op_r       <= in_op;
      tok_r      <= in_tok;
      addr_r     <= in_addr;
      stamp_in_r <= in_stamp;
      ndelta_r   <= in_ndelta;
    end
    if (state_r == ST_READ) begin
      cnt_r   <= tok_r ? ent_new.count : '0;
      delta_r <= tok_r ? ent_new.delta : '0;
      dq_r    <= ent_new.sum;
      rem_r   <= '0;
      step_r  <= '0;
    end
    if (state_r == ST_DIV) begin
      dq_r   <= dq_nxt;
      rem_r  <= rem_nxt;
      step_r <= step_r + 1'b1;
    end
    if (state_r == ST_MUL1) begin
      mq_r <= mq_prod[44:32];
    end
    if (state_r == ST_MUL2) begin
      if (mdiff[33]) begin
        mill_r <= mq_r - 1'b1;
        mrem_r <= 20'(mdiff + 34'(ONE_MILLION));
      end else begin
        mill_r <= mq_r;
        mrem_r <= mdiff[19:0];
      end
    end
    if (state_r == ST_MUL3) begin
      tq_r <= tq_prod[30:20];
    end
    if ((state_r == ST_MUL4) && (!out_tvalid_r || out_tready)) begin
      out_data_r <= {3'b000, units_val, thou_val, mill_r, avg_r, delta_r, cnt_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// ===== rtl/ptb_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
`default_nettype none
module ptb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                     wdata,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // The read returns the old contents of the entry in the cycle after the address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire
